@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_CHECK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ src/tfs_pkg.sv @@
package tfs_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int POS_W = $clog2(CROSS_W);
  localparam int NORM_MSB = 29;
  localparam int V_W = NORM_MSB + 1;
  localparam int LIGHT_W = 16;
  localparam int DOT_W = V_W + 1 + LIGHT_W;
  localparam int D_W = DOT_W + 2;
  localparam int N_W = D_W - 1;
  localparam int SQ_W = 2 * V_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int SR_W = ROOT_W + 3;
  localparam int Q_W = N_W - NORM_MSB;
  localparam int DR_W = ROOT_W + 1;
  localparam int SHADE_W = 16;
  localparam int MUL_W = SHADE_W + Q_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [Q_W-1:0] COS_LIMIT = Q_W'(1) << (LIGHT_W + 1);

  localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 16'sd11440;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 16'sd27783;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 16'sd13075;
  localparam logic [SHADE_W-1:0] SHADE_BASE_RST = 16'd19661;
  localparam logic [SHADE_W-1:0] SHADE_GAIN_RST = 16'd45875;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X,
    CFG_LIGHT_Y,
    CFG_LIGHT_Z,
    CFG_SHADE_BASE,
    CFG_SHADE_GAIN
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][V_W-1:0] v;
    logic [2:0]          neg;
    logic                degen;
  } front_t;

  typedef struct packed {
    logic [ROOT_W-1:0] len;
    logic [N_W-1:0]    num;
    logic              degen;
  } norm_t;

endpackage

@@ src/triangle_flat_shade_top.sv @@
// Flat shading of one triangle per request.
// Input channel: in_valid / in_stall carry the nine vertex coordinates
// a_x .. c_z, signed Q8.8. Output channel: out_valid / out_stall carry
// shade (unsigned Q0.16, saturated) and degenerate. A request moves at a
// rising edge with valid high and stall low.
// Configuration: cfg_write_en with cfg_index and cfg_data writes light_x,
// light_y, light_z, shade_base or shade_gain (indexes 0 to 4); others are
// ignored. Write only while no request is in flight.
// Throughput: one triangle per cycle while out_stall does not hold the
// pipeline; it holds 61 requests, most of them in the 31 stage square root and the 19 stage divider.
// Reset (rst, synchronous) empties the pipeline and loads the default
// light direction, base and gain.
// When out_stall is high while out_valid is high the whole pipeline
// holds and in_stall rises in the same cycle; nothing is lost.
`include "assert_macros.svh"

module triangle_flat_shade_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] a_x,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] a_y,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] a_z,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] b_x,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] b_y,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] b_z,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] c_x,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] c_y,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] c_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tfs_pkg::SHADE_W-1:0]           shade,
  output logic                                  degenerate,
  input  logic                                  cfg_write_en,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tfs_pkg::LIGHT_W-1:0]           cfg_data
);

  localparam int LW = tfs_pkg::LIGHT_W;
  localparam int QW = tfs_pkg::Q_W;
  localparam int MW = tfs_pkg::MUL_W;
  localparam int SW = tfs_pkg::SHADE_W;
  localparam int NM = tfs_pkg::NORM_MSB;

  logic signed [LW-1:0] light_x, light_y, light_z;
  logic [SW-1:0] shade_base, shade_gain;
  logic en;
  logic f_valid, n_valid, d_valid, d_degen;
  tfs_pkg::front_t f_data;
  tfs_pkg::norm_t n_data;
  logic [QW-1:0] d_cosq, cos_sel;
  logic [LW-1:0] ly_mag;
  logic vm, dm;
  logic [MW-1:0] prod;
  logic [QW:0] sum;
  logic f_msb;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= tfs_pkg::LIGHT_X_RST;
      light_y <= tfs_pkg::LIGHT_Y_RST;
      light_z <= tfs_pkg::LIGHT_Z_RST;
      shade_base <= tfs_pkg::SHADE_BASE_RST;
      shade_gain <= tfs_pkg::SHADE_GAIN_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        tfs_pkg::CFG_LIGHT_X: light_x <= cfg_data;
        tfs_pkg::CFG_LIGHT_Y: light_y <= cfg_data;
        tfs_pkg::CFG_LIGHT_Z: light_z <= cfg_data;
        tfs_pkg::CFG_SHADE_BASE: shade_base <= cfg_data;
        tfs_pkg::CFG_SHADE_GAIN: shade_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  tfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .c_x      (c_x),
    .c_y      (c_y),
    .c_z      (c_z),
    .valid    (f_valid),
    .data     (f_data)
  );

  tfs_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .f        (f_data),
    .light_x  (light_x),
    .light_y  (light_y),
    .light_z  (light_z),
    .valid    (n_valid),
    .data     (n_data)
  );

  tfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (n_valid),
    .n        (n_data),
    .valid    (d_valid),
    .cosq     (d_cosq),
    .degen    (d_degen)
  );

  // flat normal (0,1,0) gives twice |light_y|
  assign ly_mag = light_y[LW-1] ? LW'(-light_y) : LW'(light_y);
  assign cos_sel = d_degen ? QW'({ly_mag, 1'b0}) : d_cosq;
  assign sum = (QW + 1)'(shade_base) + (QW + 1)'(prod >> SW);
  assign f_msb = f_data.v[0][NM] || f_data.v[1][NM] || f_data.v[2][NM];

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vm <= d_valid;
      out_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= MW'(shade_gain) * MW'(cos_sel);
      dm <= d_degen;
      shade <= (|sum[QW:SW]) ? '1 : sum[SW-1:0];
      degenerate <= dm;
    end
  end

  `ASSERT_CHECK(a_degen_zero, clk, rst, f_valid && f_data.degen |-> f_data.v == '0)
  `ASSERT_CHECK(a_norm_msb, clk, rst, f_valid && !f_data.degen |-> f_msb)
  `ASSERT_NEVER(a_cos_range, clk, rst, d_valid && !d_degen && d_cosq >= tfs_pkg::COS_LIMIT)

endmodule

@@ src/tfs_front.sv @@
module tfs_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] a_x,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] a_y,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] a_z,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] b_x,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] b_y,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] b_z,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] c_x,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] c_y,
  input  logic signed [tfs_pkg::COORD_BITS-1:0] c_z,
  output logic                                 valid,
  output tfs_pkg::front_t                      data
);

  localparam int DW = tfs_pkg::DIFF_W;
  localparam int PW = tfs_pkg::PROD_W;
  localparam int CW = tfs_pkg::CROSS_W;
  localparam int SW = tfs_pkg::POS_W;
  localparam int VW = tfs_pkg::V_W;
  localparam int NM = tfs_pkg::NORM_MSB;

  logic [6:0] vld;
  logic signed [DW-1:0] u [0:2];
  logic signed [DW-1:0] w [0:2];
  logic signed [PW-1:0] pr [0:5];
  logic signed [CW-1:0] cr [0:2];
  logic [CW-1:0] cm4 [0:2];
  logic [CW-1:0] cm5 [0:2];
  logic [CW-1:0] cm6 [0:2];
  logic [2:0] ng4, ng5, ng6;
  logic [CW-1:0] mx, mx_next;
  logic [SW-1:0] pos, pos_next;
  logic dg6;
  logic [VW-1:0] v_next [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_comb begin
    mx_next = cm4[0];
    if (cm4[1] > mx_next) begin
      mx_next = cm4[1];
    end
    if (cm4[2] > mx_next) begin
      mx_next = cm4[2];
    end
  end

  // leading one of the largest magnitude
  always_comb begin
    pos_next = '0;
    for (int i = 0; i < CW; i++) begin
      if (mx[i]) begin
        pos_next = SW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos >= SW'(NM)) begin
        v_next[i] = VW'(cm6[i] >> (pos - SW'(NM)));
      end else begin
        v_next[i] = VW'(cm6[i]) << (SW'(NM) - pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= DW'(b_x) - DW'(a_x);
      u[1] <= DW'(b_y) - DW'(a_y);
      u[2] <= DW'(b_z) - DW'(a_z);
      w[0] <= DW'(c_x) - DW'(a_x);
      w[1] <= DW'(c_y) - DW'(a_y);
      w[2] <= DW'(c_z) - DW'(a_z);

      pr[0] <= u[1] * w[2];
      pr[1] <= u[2] * w[1];
      pr[2] <= u[2] * w[0];
      pr[3] <= u[0] * w[2];
      pr[4] <= u[0] * w[1];
      pr[5] <= u[1] * w[0];

      cr[0] <= CW'(pr[0]) - CW'(pr[1]);
      cr[1] <= CW'(pr[2]) - CW'(pr[3]);
      cr[2] <= CW'(pr[4]) - CW'(pr[5]);

      for (int i = 0; i < 3; i++) begin
        ng4[i] <= cr[i][CW-1];
        cm4[i] <= cr[i][CW-1] ? CW'(-cr[i]) : CW'(cr[i]);
        cm5[i] <= cm4[i];
        cm6[i] <= cm5[i];
        data.v[i] <= v_next[i];
      end
      ng5 <= ng4;
      ng6 <= ng5;
      mx <= mx_next;
      pos <= pos_next;
      dg6 <= (mx == '0);
      data.neg <= ng6;
      data.degen <= dg6;
    end
  end

  assign valid = vld[6];

endmodule

@@ src/tfs_norm.sv @@
module tfs_norm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  tfs_pkg::front_t                   f,
  input  logic signed [tfs_pkg::LIGHT_W-1:0] light_x,
  input  logic signed [tfs_pkg::LIGHT_W-1:0] light_y,
  input  logic signed [tfs_pkg::LIGHT_W-1:0] light_z,
  output logic                              valid,
  output tfs_pkg::norm_t                    data
);

  localparam int VW = tfs_pkg::V_W;
  localparam int QW = tfs_pkg::SQ_W;
  localparam int TW = tfs_pkg::DOT_W;
  localparam int DW = tfs_pkg::D_W;
  localparam int NW = tfs_pkg::N_W;
  localparam int UW = tfs_pkg::SUM_W;
  localparam int RW = tfs_pkg::ROOT_W;
  localparam int XW = tfs_pkg::SR_W;

  typedef struct packed {
    logic          valid;
    logic [UW-1:0] x;
    logic [XW-1:0] rem;
    logic [RW-1:0] root;
    logic [NW-1:0] num;
    logic          degen;
  } sq_stage_t;

  logic signed [VW:0] rs [0:2];
  logic signed [tfs_pkg::LIGHT_W-1:0] lt [0:2];
  logic [QW-1:0] sq [0:2];
  logic signed [TW-1:0] dp [0:2];
  logic va, vb, dga, dgb;
  logic [UW-1:0] sum;
  logic signed [DW-1:0] d;
  logic [DW-1:0] ad;
  sq_stage_t stg [0:RW];

  always_comb begin
    lt[0] = light_x;
    lt[1] = light_y;
    lt[2] = light_z;
    for (int i = 0; i < 3; i++) begin
      rs[i] = f.neg[i] ? -$signed({1'b0, f.v[i]}) : $signed({1'b0, f.v[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= QW'(f.v[i]) * QW'(f.v[i]);
        dp[i] <= rs[i] * lt[i];
      end
      dga <= f.degen;
      sum <= UW'(sq[0]) + UW'(sq[1]) + UW'(sq[2]);
      d <= DW'(dp[0]) + DW'(dp[1]) + DW'(dp[2]);
      dgb <= dga;
    end
  end

  assign ad = d[DW-1] ? DW'(-d) : DW'(d);

  always_comb begin
    stg[0].valid = vb;
    stg[0].x = sum;
    stg[0].rem = '0;
    stg[0].root = '0;
    stg[0].num = NW'(ad << 1);
    stg[0].degen = dgb;
  end

  // one root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [XW-1:0] t, trial;
    logic ge;

    assign t = {stg[k].rem[XW-3:0], stg[k].x[UW-1 -: 2]};
    assign trial = XW'({stg[k].root, 2'b01});
    assign ge = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k+1].valid <= 1'b0;
      end else if (en) begin
        stg[k+1].valid <= stg[k].valid;
        stg[k+1].x <= stg[k].x << 2;
        stg[k+1].rem <= ge ? t - trial : t;
        stg[k+1].root <= {stg[k].root[RW-2:0], ge};
        stg[k+1].num <= stg[k].num;
        stg[k+1].degen <= stg[k].degen;
      end
    end
  end

  assign valid = stg[RW].valid;
  assign data.len = stg[RW].root;
  assign data.num = stg[RW].num;
  assign data.degen = stg[RW].degen;

endmodule

@@ src/tfs_div.sv @@
module tfs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  tfs_pkg::norm_t            n,
  output logic                      valid,
  output logic [tfs_pkg::Q_W-1:0]   cosq,
  output logic                      degen
);

  localparam int QW = tfs_pkg::Q_W;
  localparam int DW = tfs_pkg::DR_W;
  localparam int RW = tfs_pkg::ROOT_W;
  localparam int NW = tfs_pkg::N_W;

  typedef struct packed {
    logic          valid;
    logic [DW-1:0] rem;
    logic [QW-1:0] y;
    logic [QW-1:0] q;
    logic [RW-1:0] len;
    logic          degen;
  } div_stage_t;

  div_stage_t stg [0:QW];

  always_comb begin
    stg[0].valid = in_valid;
    stg[0].rem = DW'(n.num[NW-1:QW]);
    stg[0].y = n.num[QW-1:0];
    stg[0].q = '0;
    stg[0].len = n.len;
    stg[0].degen = n.degen;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW-1:0] t, dv;
    logic ge;

    assign t = {stg[k].rem[DW-2:0], stg[k].y[QW-1]};
    assign dv = DW'(stg[k].len);
    assign ge = (t >= dv);

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k+1].valid <= 1'b0;
      end else if (en) begin
        stg[k+1].valid <= stg[k].valid;
        stg[k+1].rem <= ge ? t - dv : t;
        stg[k+1].y <= stg[k].y << 1;
        stg[k+1].q <= {stg[k].q[QW-2:0], ge};
        stg[k+1].len <= stg[k].len;
        stg[k+1].degen <= stg[k].degen;
      end
    end
  end

  assign valid = stg[QW].valid;
  assign cosq = stg[QW].q;
  assign degen = stg[QW].degen;

endmodule

@@ dv/tb_top.sv @@
module tb_top;

  localparam int NUM_RANDOM = 498;
  localparam int PIPE_DEPTH = 61;

  typedef struct {
    logic signed [15:0] c[9];
  } tri_t;

  typedef struct packed {
    logic [15:0] shade;
    logic        degen;
  } shade_res_t;

  typedef struct {
    tri_t       t;
    bit         has_exp;
    shade_res_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [15:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [15:0] c_x = '0, c_y = '0, c_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] shade;
  logic degenerate;
  logic cfg_write_en = 1'b0;
  logic [tfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tfs_pkg::LIGHT_W-1:0] cfg_data = '0;

  longint lx, ly, lz, base_r, gain_r;
  shade_res_t shade_q[$];
  int errors = 0;
  bit long_hold = 0;
  bit stall_enable = 1;

  triangle_flat_shade_top dut (.*);

  always #5 clk = ~clk;

  initial begin
    #40000000;
    $display("[triangle_flat_shade_top] ERROR");
    $finish;
  end

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root64(longint x);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic shade_res_t lambert_shade(tri_t t);
    shade_res_t r;
    longint p[9], u[3], w[3], cr[3], cm[3], rv[3], m, s, sum, len, d, cosq, sh;
    int up, down;
    for (int i = 0; i < 9; i++) p[i] = t.c[i];
    for (int i = 0; i < 3; i++) begin
      u[i] = p[3+i] - p[i];
      w[i] = p[6+i] - p[i];
    end
    cr[0] = u[1]*w[2] - u[2]*w[1];
    cr[1] = u[2]*w[0] - u[0]*w[2];
    cr[2] = u[0]*w[1] - u[1]*w[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      cm[i] = absl(cr[i]);
      if (cm[i] > m) m = cm[i];
    end
    r.degen = (m == 0);
    if (r.degen) begin
      cosq = 2 * absl(ly);
    end else begin
      up = 0; down = 0; s = m;
      while (s >= (64'sd1 << 30)) begin s >>= 1; down++; end
      while (s < (64'sd1 << 29)) begin s <<= 1; up++; end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        rv[i] = (cm[i] >> down) << up;
        sum += rv[i] * rv[i];
        if (cr[i] < 0) rv[i] = -rv[i];
      end
      len = root64(sum);
      d = rv[0]*lx + rv[1]*ly + rv[2]*lz;
      cosq = (2 * absl(d)) / len;
    end
    sh = base_r + ((gain_r * cosq) >> 16);
    r.shade = sh > 65535 ? 16'hFFFF : sh[15:0];
    return r;
  endfunction

  task automatic write_reg(tfs_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    @(negedge clk);
    case (idx)
      tfs_pkg::CFG_LIGHT_X: lx = $signed(val);
      tfs_pkg::CFG_LIGHT_Y: ly = $signed(val);
      tfs_pkg::CFG_LIGHT_Z: lz = $signed(val);
      tfs_pkg::CFG_SHADE_BASE: base_r = val;
      default: gain_r = val;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (shade_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 5) @(negedge clk);
  endtask

  task automatic send_tri(tri_t t, bit has_exp, shade_res_t e, bit no_gap);
    shade_res_t pred;
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <=
      {t.c[0], t.c[1], t.c[2], t.c[3], t.c[4], t.c[5], t.c[6], t.c[7], t.c[8]};
    in_valid <= 1'b1;
    pred = lambert_shade(t);
    if (has_exp && pred != e) begin
      $error("directed row: predictor gives shade %0d degen %0d, table %0d %0d",
             pred.shade, pred.degen, e.shade, e.degen);
      errors++;
    end
    do @(posedge clk); while (in_stall);
    shade_q.insert(shade_q.size(), pred);
    @(negedge clk);
  endtask

  function automatic tri_t rand_tri(int kind);
    tri_t t;
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0: t.c[i] = 16'($urandom);
        1: t.c[i] = 16'(int'($urandom_range(0, 1023)) - 512);
        default: t.c[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      endcase
    end
    if (kind == 3) for (int i = 0; i < 3; i++) t.c[3+i] = t.c[i];
    if (kind == 4) for (int i = 0; i < 3; i++) t.c[6+i] = 16'(2*t.c[3+i] - t.c[i]);
    return t;
  endfunction

  function automatic tri_t mk(int v[9]);
    tri_t t;
    for (int i = 0; i < 9; i++) t.c[i] = 16'(v[i]);
    return t;
  endfunction

  task automatic random_settings(int mode);
    if (mode == 0) begin
      write_reg(tfs_pkg::CFG_LIGHT_X, 16'h8000); write_reg(tfs_pkg::CFG_LIGHT_Y, 16'h7FFF);
      write_reg(tfs_pkg::CFG_LIGHT_Z, 16'h8000); write_reg(tfs_pkg::CFG_SHADE_BASE, 16'hFFFF);
      write_reg(tfs_pkg::CFG_SHADE_GAIN, 16'hFFFF);
    end else if (mode == 1) begin
      write_reg(tfs_pkg::CFG_LIGHT_X, 16'h0000); write_reg(tfs_pkg::CFG_LIGHT_Y, 16'h0000);
      write_reg(tfs_pkg::CFG_LIGHT_Z, 16'h0000); write_reg(tfs_pkg::CFG_SHADE_BASE, 16'h0000);
      write_reg(tfs_pkg::CFG_SHADE_GAIN, 16'h0000);
    end else begin
      write_reg(tfs_pkg::CFG_LIGHT_X, 16'($urandom));
      write_reg(tfs_pkg::CFG_LIGHT_Y, 16'($urandom));
      write_reg(tfs_pkg::CFG_LIGHT_Z, 16'($urandom));
      write_reg(tfs_pkg::CFG_SHADE_BASE, 16'($urandom_range(0, 30000)));
      write_reg(tfs_pkg::CFG_SHADE_GAIN, 16'($urandom));
    end
    cfg_write_en <= 1'b0;
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) out_stall <= 1'b1;
      else if (!stall_enable) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 10) < 4);
    end
  end

  always @(posedge clk) begin
    shade_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (shade_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = shade_q.pop_front();
        if (shade !== e.shade) begin
          $error("shade expected %0d actual %0d", e.shade, shade);
          errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate expected %0d actual %0d", e.degen, degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    lx = tfs_pkg::LIGHT_X_RST; ly = tfs_pkg::LIGHT_Y_RST; lz = tfs_pkg::LIGHT_Z_RST;
    base_r = tfs_pkg::SHADE_BASE_RST; gain_r = tfs_pkg::SHADE_GAIN_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // degenerate after reset: base + gain*2*27783>>16 = 19661 + 38896
    row.has_exp = 1;
    row.t = mk('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    row.exp = '{16'd58557, 1'b1}; rows.insert(rows.size(), row);
    row.t = mk('{256, 256, 256, 256, 256, 256, 512, 0, 0});
    rows.insert(rows.size(), row);
    row.t = mk('{0, 0, 0, 256, 256, 256, 512, 512, 512});
    rows.insert(rows.size(), row);
    row.t = mk('{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768});
    rows.insert(rows.size(), row);
    row.has_exp = 0;
    row.t = mk('{0, 0, 0, 256, 0, 0, 0, 256, 0}); rows.insert(rows.size(), row);
    row.t = mk('{0, 0, 0, 0, 0, 256, 256, 0, 0}); rows.insert(rows.size(), row);
    row.t = mk('{0, 0, 0, 0, 256, 0, 0, 0, 256}); rows.insert(rows.size(), row);
    row.t = mk('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768});
    rows.insert(rows.size(), row);
    row.t = mk('{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768});
    rows.insert(rows.size(), row);
    row.t = mk('{0, 0, 0, 1, 0, 0, 0, 1, 0}); rows.insert(rows.size(), row);
    row.t = mk('{-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767});
    rows.insert(rows.size(), row);
    row.t = mk('{5, -7, 3, 1000, 20, -300, -40, 600, 2}); rows.insert(rows.size(), row);
    foreach (rows[i]) send_tri(rows[i].t, rows[i].has_exp, rows[i].exp, 0);
    drain();

    // saturation and zero extremes
    random_settings(0);
    for (int i = 0; i < 8; i++) send_tri(rand_tri(i % 5), 0, row.exp, 0);
    drain();
    random_settings(1);
    for (int i = 0; i < 8; i++) send_tri(rand_tri(i % 5), 0, row.exp, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_settings(ph == 5 ? 0 : 2);
      if (ph == 2) begin
        // long receiver hold while requests keep coming
        fork
          begin
            long_hold = 1;
            repeat (150) @(negedge clk);
            long_hold = 0;
          end
          for (int i = 0; i < 80; i++) send_tri(rand_tri($urandom_range(0, 4)), 0, row.exp, 1);
        join
      end
      if (ph == 3) stall_enable = 0;
      for (int i = 0; i < NUM_RANDOM / 6; i++)
        send_tri(rand_tri($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 4)), 0, row.exp,
                 ph == 3);
      stall_enable = 1;
      drain();
    end

    drain();
    if (errors == 0) $display("[triangle_flat_shade_top] OK");
    else $display("[triangle_flat_shade_top] ERROR");
    $finish;
  end

endmodule
